FILE: sv/qslerp_pkg.sv
// Shared types, widths and constants of the quaternion slerp block.
// Holds the arctangent table used by both CORDIC engines in the back end.
// No dependencies.
package qslerp_pkg;

  // Component and blend formats
  localparam int CMP_W       = 16;                 // Q2.14 component
  localparam int FRAC        = 14;                 // component fraction bits
  localparam int DOT_FRAC    = 2 * FRAC;           // dot product fraction bits
  localparam int T_W         = 17;                 // Q1.16 blend time, 0..1
  localparam int NEG_W       = CMP_W + 1;          // negated component, no wrap
  localparam int D30_W       = 31;                 // Q1.30 dot, at most one
  localparam int TRIG_ITER   = 16;                 // CORDIC iterations
  localparam int QDEPTH      = 4;                  // front to back queue depth
  localparam logic [T_W-1:0] T_ONE      = T_W'(65536);
  localparam logic [T_W-1:0] THR_RESET  = T_W'(3277);
  localparam logic [31:0]    INV_GAIN   = 32'h26DD3B6A;

  // One item as it travels through the back end
  typedef struct packed {
    logic                          lin;   // lerp chosen by the dot compare
    logic [T_W-1:0]                t;     // saturated blend time
    logic [3:0][CMP_W-1:0]         b;     // second quaternion
    logic [3:0][NEG_W-1:0]         a;     // first quaternion, short-arc sign applied
  } pay_t;

  // Queue entry written by the front end
  typedef struct packed {
    pay_t              pay;
    logic [D30_W-1:0]  d30;   // |dot| in Q1.30, zero for lerp items
  } entry_t;

  // Arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      24: r = 32'h0000003F;
      25: r = 32'h0000001F;
      26: r = 32'h0000000F;
      27: r = 32'h00000008;
      28: r = 32'h00000004;
      29: r = 32'h00000002;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/qs_front.sv
// Front end: accepts input beats, forms the dot product and picks slerp or lerp.
// Holds the threshold register. Depends on qslerp_pkg.
module qs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [16:0]               cfg_wr_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [151:0]              in_data_i,
  output logic                      enq_valid_o,
  input  logic                      enq_ready_i,
  output qslerp_pkg::entry_t        enq_data_o
);

  localparam int CW    = qslerp_pkg::CMP_W;
  localparam int PW    = 2 * CW;
  localparam int DW    = PW + 2;
  localparam int LW    = DW + 1;
  localparam int TW    = qslerp_pkg::T_W;

  logic [TW-1:0]              thr_q;
  logic                       f1_v_q, f2_v_q;
  logic                       f1_adv, f2_move;
  logic signed [PW-1:0]       prod_q [4];
  logic [3:0][CW-1:0]         a_q, b_q;
  logic [TW-1:0]              t_q;
  logic [TW-1:0]              t_in;
  qslerp_pkg::entry_t         ent_d, ent_q;
  logic signed [DW-1:0]       dot;
  logic                       dot_neg;
  logic [DW-2:0]              dot_abs;
  logic signed [LW-1:0]       limit;
  logic                       slerp_ok;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qslerp_pkg::THR_RESET;
    end else if (cfg_wr_en_i) begin
      thr_q <= cfg_wr_data_i;
    end
  end

  // Handshake between the two front stages and the queue
  assign f2_move     = f2_v_q && enq_ready_i;
  assign f1_adv      = !f2_v_q || f2_move;
  assign in_ready_o  = !f1_v_q || f1_adv;
  assign enq_valid_o = f2_v_q;
  assign enq_data_o  = ent_q;

  // Saturate blend time at one
  assign t_in = (in_data_i[8*CW +: TW] > qslerp_pkg::T_ONE) ? qslerp_pkg::T_ONE
                                                           : in_data_i[8*CW +: TW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (in_ready_o) f1_v_q <= in_valid_i;
      if (f1_adv)     f2_v_q <= f1_v_q;
    end
  end

  // Stage one: component products
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      for (int k = 0; k < 4; k++) begin
        a_q[k]    <= in_data_i[k*CW +: CW];
        b_q[k]    <= in_data_i[(4+k)*CW +: CW];
        prod_q[k] <= $signed(in_data_i[k*CW +: CW]) * $signed(in_data_i[(4+k)*CW +: CW]);
      end
      t_q <= t_in;
    end
  end

  // Stage two: sum, short-arc flip and closeness compare
  always_comb begin
    dot      = DW'(prod_q[0]) + DW'(prod_q[1]) + DW'(prod_q[2]) + DW'(prod_q[3]);
    dot_neg  = dot[DW-1];
    dot_abs  = dot_neg ? (DW-1)'(-dot) : (DW-1)'(dot);
    limit    = (LW'(1) << qslerp_pkg::DOT_FRAC)
             - (LW'(thr_q) << (qslerp_pkg::DOT_FRAC - 16));
    slerp_ok = $signed({2'b00, dot_abs}) <= limit;
    for (int k = 0; k < 4; k++) begin
      ent_d.pay.a[k] = dot_neg ? -{a_q[k][CW-1], a_q[k]} : {a_q[k][CW-1], a_q[k]};
      ent_d.pay.b[k] = b_q[k];
    end
    ent_d.pay.t   = t_q;
    ent_d.pay.lin = !slerp_ok;
    ent_d.d30     = slerp_ok
                  ? qslerp_pkg::D30_W'(dot_abs << (30 - qslerp_pkg::DOT_FRAC))
                  : '0;
  end

  always_ff @(posedge clk_i) begin
    if (f1_adv && f1_v_q) begin
      ent_q <= ent_d;
    end
  end

endmodule

FILE: sv/qs_fifo.sv
// Short queue between the front and back ends of the slerp block. Register based;
// one write per cycle unless full, one read unless empty. Depends on qslerp_pkg.
module qs_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  qslerp_pkg::entry_t    wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_pop_i,
  output qslerp_pkg::entry_t    rd_data_o
);

  localparam int D  = qslerp_pkg::QDEPTH;
  localparam int AW = $clog2(D);
  localparam int CW = $clog2(D + 1);

  qslerp_pkg::entry_t  mem_q [D];
  logic [AW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]       cnt_q;
  logic                push, pop;

  assign wr_ready_o = cnt_q != CW'(D);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == AW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == AW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(D)) else $error("queue count beyond depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CW'(D)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step with count");

endmodule

FILE: sv/qs_back.sv
// Back end: square root, vectoring and rotation CORDIC, weight division and blend.
// A single stall enable moves the whole pipeline. Depends on qslerp_pkg.
module qs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  deq_valid_i,
  output logic                  deq_pop_o,
  input  qslerp_pkg::entry_t    deq_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           out_data_o,
  output logic                  out_user_o
);

  localparam int CMP   = qslerp_pkg::CMP_W;
  localparam int NW    = qslerp_pkg::NEG_W;
  localparam int TW    = qslerp_pkg::T_W;
  localparam int RT_W  = qslerp_pkg::D30_W;       // root bits
  localparam int SQ_W  = 2 * RT_W + 1;            // radicand and trial
  localparam int SQ_N  = RT_W;                    // one root bit per stage
  localparam int VC_N  = qslerp_pkg::TRIG_ITER;
  localparam int RC_N  = qslerp_pkg::TRIG_ITER;
  localparam int CW    = 35;                      // CORDIC datapath
  localparam int MW    = CW + TW + 1;             // theta times t
  localparam int DQ_N  = 34;                      // quotient bits
  localparam int DV_W  = RT_W + DQ_N + 1;         // division remainder
  localparam int WW    = 35;                      // weight, Q5.30 up to four
  localparam int PW    = WW + NW;                 // weight times component
  localparam int AW    = PW + 1;
  localparam int LSH   = 30 - 16;                 // lerp weight to Q5.30

  // Pipeline stage positions
  localparam int P_E0  = 0;
  localparam int P_E1  = P_E0 + 1;
  localparam int P_SQ  = P_E1 + 1;
  localparam int P_VC  = P_SQ + SQ_N;
  localparam int P_ML  = P_VC + VC_N;
  localparam int P_RC  = P_ML + 1;
  localparam int P_D0  = P_RC + RC_N;
  localparam int P_DV  = P_D0 + 1;
  localparam int P_WT  = P_DV + DQ_N;
  localparam int P_PM  = P_WT + 1;
  localparam int NST   = P_PM + 1;

  localparam logic [DQ_N-1:0] WLIM = DQ_N'(1) << 32;

  logic                    adv;
  logic                    pv_q [NST];
  qslerp_pkg::pay_t        pay_q [NST];

  logic [RT_W-1:0]         e0_d30_q, e1_d30_q;
  logic [SQ_W-1:0]         e1_rad_q;
  logic [2*RT_W-1:0]       d_sq;

  logic [RT_W-1:0]         sq_root_d [SQ_N], sq_root_q [SQ_N];
  logic [SQ_W-1:0]         sq_rem_d [SQ_N],  sq_rem_q [SQ_N];
  logic [RT_W-1:0]         sq_d30_d [SQ_N],  sq_d30_q [SQ_N];

  logic signed [CW-1:0]    vc_x_d [VC_N], vc_x_q [VC_N];
  logic signed [CW-1:0]    vc_y_d [VC_N], vc_y_q [VC_N];
  logic signed [CW-1:0]    vc_z_d [VC_N], vc_z_q [VC_N];
  logic [RT_W-1:0]         vc_s_d [VC_N], vc_s_q [VC_N];

  logic signed [MW-1:0]    ml_prod;
  logic signed [CW-1:0]    ml_angb;
  logic signed [CW-1:0]    ml_ang_q [2];
  logic [RT_W-1:0]         ml_s_q;

  logic signed [CW-1:0]    rc_x_d [RC_N][2], rc_x_q [RC_N][2];
  logic signed [CW-1:0]    rc_y_d [RC_N][2], rc_y_q [RC_N][2];
  logic signed [CW-1:0]    rc_z_d [RC_N][2], rc_z_q [RC_N][2];
  logic [RT_W-1:0]         rc_s_d [RC_N],    rc_s_q [RC_N];

  logic [DV_W-1:0]         d0_rem_d [2], d0_rem_q [2];
  logic                    d0_ovf_d [2], d0_ovf_q [2];
  logic                    d0_neg_d [2], d0_neg_q [2];
  logic [RT_W-1:0]         d0_s_q;

  logic [DV_W-1:0]         dv_rem_d [DQ_N][2], dv_rem_q [DQ_N][2];
  logic [DQ_N-1:0]         dv_quo_d [DQ_N][2], dv_quo_q [DQ_N][2];
  logic                    dv_ovf_q [DQ_N][2], dv_neg_q [DQ_N][2];
  logic [RT_W-1:0]         dv_s_q [DQ_N];

  logic signed [WW-1:0]    wt_w_d [2], wt_w_q [2];
  logic                    wt_lin_d, wt_lin_q;

  logic signed [PW-1:0]    pm_a_d [4], pm_a_q [4];
  logic signed [PW-1:0]    pm_b_d [4], pm_b_q [4];
  logic                    pm_lin_q;

  logic                    out_v_q;
  logic [3:0][CMP-1:0]     out_res_d, out_res_q;
  logic                    out_lin_q;

  // Whole pipeline moves when the output register is free or being taken
  assign adv        = !out_v_q || out_ready_i;
  assign deq_pop_o  = adv && deq_valid_i;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_res_q;
  assign out_user_o = out_lin_q;

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) pv_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      pv_q[0] <= deq_valid_i;
      for (int k = 1; k < NST; k++) pv_q[k] <= pv_q[k-1];
      out_v_q <= pv_q[NST-1];
    end
  end

  // Item payload follows its stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pay_q[0] <= deq_data_i.pay;
      for (int k = 1; k < NST; k++) pay_q[k] <= pay_q[k-1];
    end
  end

  // Radicand 1 - d^2 in Q3.60
  assign d_sq = e0_d30_q * e0_d30_q;

  // Square root, one result bit per stage
  always_comb begin
    logic [RT_W-1:0] root_in;
    logic [SQ_W-1:0] rem_in;
    logic [RT_W-1:0] d_in;
    logic [SQ_W-1:0] trial;
    int              bp;
    for (int k = 0; k < SQ_N; k++) begin
      bp = SQ_N - 1 - k;
      if (k == 0) begin
        root_in = '0;
        rem_in  = e1_rad_q;
        d_in    = e1_d30_q;
      end else begin
        root_in = sq_root_q[k-1];
        rem_in  = sq_rem_q[k-1];
        d_in    = sq_d30_q[k-1];
      end
      trial = (SQ_W'(root_in) << (bp + 1)) + (SQ_W'(1) << (2 * bp));
      if (rem_in >= trial) begin
        sq_rem_d[k]  = rem_in - trial;
        sq_root_d[k] = root_in | (RT_W'(1) << bp);
      end else begin
        sq_rem_d[k]  = rem_in;
        sq_root_d[k] = root_in;
      end
      sq_d30_d[k] = d_in;
    end
  end

  // Vectoring CORDIC: theta from (cos, sin)
  always_comb begin
    logic signed [CW-1:0] xi, yi, zi;
    logic [RT_W-1:0]      si;
    for (int k = 0; k < VC_N; k++) begin
      if (k == 0) begin
        xi = CW'(sq_d30_q[SQ_N-1]);
        yi = CW'(sq_root_q[SQ_N-1]);
        zi = '0;
        si = sq_root_q[SQ_N-1];
      end else begin
        xi = vc_x_q[k-1];
        yi = vc_y_q[k-1];
        zi = vc_z_q[k-1];
        si = vc_s_q[k-1];
      end
      if (yi > 0) begin
        vc_x_d[k] = xi + (yi >>> k);
        vc_y_d[k] = yi - (xi >>> k);
        vc_z_d[k] = zi + CW'(qslerp_pkg::atan_q30(k));
      end else begin
        vc_x_d[k] = xi - (yi >>> k);
        vc_y_d[k] = yi + (xi >>> k);
        vc_z_d[k] = zi - CW'(qslerp_pkg::atan_q30(k));
      end
      vc_s_d[k] = si;
    end
  end

  // Split theta by the blend time
  assign ml_prod = vc_z_q[VC_N-1] * $signed({1'b0, pay_q[P_ML-1].t});
  assign ml_angb = CW'(ml_prod >>> 16);

  // Rotation CORDIC, two lanes: sin((1-t) theta) and sin(t theta)
  always_comb begin
    logic signed [CW-1:0] xi, yi, zi;
    for (int k = 0; k < RC_N; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          xi = CW'(qslerp_pkg::INV_GAIN);
          yi = '0;
          zi = ml_ang_q[l];
        end else begin
          xi = rc_x_q[k-1][l];
          yi = rc_y_q[k-1][l];
          zi = rc_z_q[k-1][l];
        end
        if (zi >= 0) begin
          rc_x_d[k][l] = xi - (yi >>> k);
          rc_y_d[k][l] = yi + (xi >>> k);
          rc_z_d[k][l] = zi - CW'(qslerp_pkg::atan_q30(k));
        end else begin
          rc_x_d[k][l] = xi + (yi >>> k);
          rc_y_d[k][l] = yi - (xi >>> k);
          rc_z_d[k][l] = zi + CW'(qslerp_pkg::atan_q30(k));
        end
      end
      rc_s_d[k] = (k == 0) ? ml_s_q : rc_s_q[k-1];
    end
  end

  // Division set-up: magnitude, sign and overflow of sin << 30 / sin(theta)
  always_comb begin
    logic signed [CW-1:0] yi;
    logic [CW-1:0]        mag;
    logic [DV_W-1:0]      num;
    for (int l = 0; l < 2; l++) begin
      yi          = rc_y_q[RC_N-1][l];
      mag         = (yi < 0) ? CW'(-yi) : CW'(yi);
      num         = DV_W'(mag) << 30;
      d0_neg_d[l] = yi < 0;
      d0_ovf_d[l] = num >= (DV_W'(rc_s_q[RC_N-1]) << DQ_N);
      d0_rem_d[l] = num;
    end
  end

  // Restoring division, one quotient bit per stage
  always_comb begin
    logic [DV_W-1:0] rem_in, dsh;
    logic [DQ_N-1:0] quo_in;
    int              bp;
    for (int k = 0; k < DQ_N; k++) begin
      bp = DQ_N - 1 - k;
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          rem_in = d0_rem_q[l];
          quo_in = '0;
          dsh    = DV_W'(d0_s_q) << bp;
        end else begin
          rem_in = dv_rem_q[k-1][l];
          quo_in = dv_quo_q[k-1][l];
          dsh    = DV_W'(dv_s_q[k-1]) << bp;
        end
        if (rem_in >= dsh) begin
          dv_rem_d[k][l] = rem_in - dsh;
          dv_quo_d[k][l] = quo_in | (DQ_N'(1) << bp);
        end else begin
          dv_rem_d[k][l] = rem_in;
          dv_quo_d[k][l] = quo_in;
        end
      end
    end
  end

  // Clamp weights, or swap in the lerp weights
  always_comb begin
    logic [DQ_N-1:0] mag;
    wt_lin_d = pay_q[P_WT-1].lin || (dv_s_q[DQ_N-1] == '0);
    for (int l = 0; l < 2; l++) begin
      mag = (dv_ovf_q[DQ_N-1][l] || dv_quo_q[DQ_N-1][l] > WLIM) ? WLIM
                                                                : dv_quo_q[DQ_N-1][l];
      wt_w_d[l] = dv_neg_q[DQ_N-1][l] ? -WW'(mag) : WW'(mag);
    end
    if (wt_lin_d) begin
      wt_w_d[0] = WW'(qslerp_pkg::T_ONE - pay_q[P_WT-1].t) << LSH;
      wt_w_d[1] = WW'(pay_q[P_WT-1].t) << LSH;
    end
  end

  // Weighted products
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pm_a_d[k] = wt_w_q[0] * $signed(pay_q[P_PM-1].a[k]);
      pm_b_d[k] = wt_w_q[1] * $signed(pay_q[P_PM-1].b[k]);
    end
  end

  // Round, shift and saturate
  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] sh;
    for (int k = 0; k < 4; k++) begin
      acc = AW'(pm_a_q[k]) + AW'(pm_b_q[k]) + (AW'(1) <<< 29);
      sh  = acc >>> 30;
      if (sh > AW'(32767))       out_res_d[k] = CMP'(16'h7FFF);
      else if (sh < -AW'(32768)) out_res_d[k] = CMP'(16'h8000);
      else                       out_res_d[k] = CMP'(sh);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e0_d30_q <= deq_data_i.d30;
      e1_d30_q <= e0_d30_q;
      e1_rad_q <= (SQ_W'(1) << 60) - SQ_W'(d_sq);
      for (int k = 0; k < SQ_N; k++) begin
        sq_root_q[k] <= sq_root_d[k];
        sq_rem_q[k]  <= sq_rem_d[k];
        sq_d30_q[k]  <= sq_d30_d[k];
      end
      for (int k = 0; k < VC_N; k++) begin
        vc_x_q[k] <= vc_x_d[k];
        vc_y_q[k] <= vc_y_d[k];
        vc_z_q[k] <= vc_z_d[k];
        vc_s_q[k] <= vc_s_d[k];
      end
      ml_ang_q[0] <= vc_z_q[VC_N-1] - ml_angb;
      ml_ang_q[1] <= ml_angb;
      ml_s_q      <= vc_s_q[VC_N-1];
      for (int k = 0; k < RC_N; k++) begin
        for (int l = 0; l < 2; l++) begin
          rc_x_q[k][l] <= rc_x_d[k][l];
          rc_y_q[k][l] <= rc_y_d[k][l];
          rc_z_q[k][l] <= rc_z_d[k][l];
        end
        rc_s_q[k] <= rc_s_d[k];
      end
      for (int l = 0; l < 2; l++) begin
        d0_rem_q[l] <= d0_rem_d[l];
        d0_ovf_q[l] <= d0_ovf_d[l];
        d0_neg_q[l] <= d0_neg_d[l];
      end
      d0_s_q <= rc_s_q[RC_N-1];
      for (int k = 0; k < DQ_N; k++) begin
        for (int l = 0; l < 2; l++) begin
          dv_rem_q[k][l] <= dv_rem_d[k][l];
          dv_quo_q[k][l] <= dv_quo_d[k][l];
          dv_ovf_q[k][l] <= (k == 0) ? d0_ovf_q[l] : dv_ovf_q[k-1][l];
          dv_neg_q[k][l] <= (k == 0) ? d0_neg_q[l] : dv_neg_q[k-1][l];
        end
        dv_s_q[k] <= (k == 0) ? d0_s_q : dv_s_q[k-1];
      end
      wt_w_q[0] <= wt_w_d[0];
      wt_w_q[1] <= wt_w_d[1];
      wt_lin_q  <= wt_lin_d;
      for (int k = 0; k < 4; k++) begin
        pm_a_q[k] <= pm_a_d[k];
        pm_b_q[k] <= pm_b_d[k];
      end
      pm_lin_q  <= wt_lin_q;
      out_res_q <= out_res_d;
      out_lin_q <= pm_lin_q;
    end
  end

endmodule

FILE: sv/quaternion_slerp.sv
// Top level of the quaternion slerp block: front end, queue and back end.
// Depends on qslerp_pkg, qs_front, qs_fifo and qs_back.
//
// Usage:
//   Slave channel s_axis_* takes one beat per quaternion pair and blend time.
//   Master channel m_axis_* returns one beat per input beat, in order, with
//   the four blended components in tdata and the lerp flag in tuser.
//   cfg_wr_en_i writes the lerp threshold (Q1.16) from cfg_wr_data_i; write it
//   only while no beat is in flight.
// Throughput: one beat per cycle while m_axis_tready does not stall the back end.
//   Every stage is a fixed pipeline step; the square root, both CORDIC engines
//   and the weight division each resolve one bit or one iteration per stage.
// Path: an input beat passes the two front stages, the queue and the back end
//   pipeline (103 stages plus the output register).
// Reset: clears all valids and the queue, and loads the threshold with 3277
//   (0.05). No clearing pass is needed.
// Stall: when m_axis_tready is low the back end holds; the four-entry queue
//   absorbs the front end, and s_axis_tready falls once it and the two front
//   stages are full.
module quaternion_slerp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_en_i,
  input  logic [16:0]   cfg_wr_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // first_x, first_y, first_z, first_w, second_x, second_y, second_z,
  // second_w, blend_time, zero pad
  input  logic [151:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // result_x, result_y, result_z, result_w
  output logic [63:0]   m_axis_tdata,
  // used_linear
  output logic          m_axis_tuser
);

  logic                enq_valid, enq_ready;
  qslerp_pkg::entry_t  enq_data;
  logic                deq_valid, deq_pop;
  qslerp_pkg::entry_t  deq_data;

  qs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .enq_valid_o   (enq_valid),
    .enq_ready_i   (enq_ready),
    .enq_data_o    (enq_data)
  );

  qs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (enq_valid),
    .wr_ready_o (enq_ready),
    .wr_data_i  (enq_data),
    .rd_valid_o (deq_valid),
    .rd_pop_i   (deq_pop),
    .rd_data_o  (deq_data)
  );

  qs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_valid_i (deq_valid),
    .deq_pop_o   (deq_pop),
    .deq_data_i  (deq_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule
